>>> hw/rtl/mld_pkg.sv
// Package for the message line deframer: word types, field codes,
// character codes and the attribute parser state encoding.
// No dependencies.
`default_nettype none

package mld_pkg;

  // Default sizing for the top level parameters
  localparam int VALUE_LIMIT_DEF = 4096;
  localparam int COUNT_BITS_DEF  = 24;

  // Width of the missing-byte report and its saturation value
  localparam int                   MORE_W   = 24;
  localparam int                   MORE_EXT = 32;
  localparam logic [MORE_EXT-1:0]  MORE_SAT = 32'h00FF_FFFF;

  // Field tags
  localparam logic [2:0] FID_SRC    = 3'd0;
  localparam logic [2:0] FID_DST    = 3'd1;
  localparam logic [2:0] FID_WDIR   = 3'd2;
  localparam logic [2:0] FID_TYPE   = 3'd3;
  localparam logic [2:0] FID_NAME   = 3'd4;
  localparam logic [2:0] FID_VALUE  = 3'd5;
  localparam logic [2:0] FID_DATA   = 3'd6;
  localparam logic [2:0] FID_STATUS = 3'd7;

  // Line positions inside a message
  localparam logic [2:0] LINE_ATTR  = 3'd4;
  localparam logic [2:0] LINE_COUNT = 3'd5;
  localparam logic [2:0] LINE_DATA  = 3'd6;

  // Count line parse phases
  localparam logic [1:0] CNT_LEAD  = 2'd0;
  localparam logic [1:0] CNT_SIGN  = 2'd1;
  localparam logic [1:0] CNT_DIGIT = 2'd2;
  localparam logic [1:0] CNT_DONE  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Attribute line parser state
  typedef enum logic [5:0] {
    AM_SKIP   = 6'b000001,
    AM_NAME   = 6'b000010,
    AM_PLAIN  = 6'b000100,
    AM_QUOTED = 6'b001000,
    AM_QPEND  = 6'b010000,
    AM_STOP   = 6'b100000
  } attr_mode_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        field_id;
    logic [7:0]        byte_out;
    logic              byte_valid;
    logic              field_end;
    logic              name_dropped;
    logic              msg_done;
    logic              msg_bad;
    logic [MORE_W-1:0] more_needed;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/message_line_deframer.sv
// Message line deframer top level: per-byte field tagging, attribute
// split, count parse and end-of-message check, with a registered output.
// Depends on mld_pkg.
//
//   channel | ports                      | word
//   --------+----------------------------+--------------------------------
//   input   | in_valid, in_stall, in_data | one message byte + last flag
//   result  | out_valid, out_stall, out_data | tagged byte and status
//
// One byte is accepted per cycle while in_stall is low; its result
// word (if any) is registered into the output register or the skid entry.
// The state update and the count's multiply by ten sit in front of them.
// A two-entry output (register plus skid) lets input flow while a result
// waits; in_stall rises only when both entries are full.
// Synchronous active-low reset empties both entries and clears the parser.
`default_nettype none

module message_line_deframer #(
  parameter int VALUE_LIMIT = mld_pkg::VALUE_LIMIT_DEF,
  parameter int COUNT_BITS  = mld_pkg::COUNT_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  mld_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output mld_pkg::out_word_t  out_data
);

  import mld_pkg::*;

  localparam int                  VLEN_W    = $clog2(VALUE_LIMIT + 1);
  localparam int                  MUL_W     = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Parser state
  logic [2:0]            line_r,  line_nxt;
  attr_mode_t            mode_r,  mode_nxt;
  logic [VLEN_W-1:0]     vlen_r,  vlen_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic                  neg_r,   neg_nxt;
  logic [COUNT_BITS-1:0] cnt_r,   cnt_nxt;
  logic                  ovf_r,   ovf_nxt;
  logic [COUNT_BITS-1:0] recv_r,  recv_nxt;

  // Output register and skid entry
  logic      out_valid_r, skid_valid_r;
  out_word_t out_data_r,  skid_data_r;

  logic       accept, out_take;
  logic [7:0] b;
  logic       last;
  logic       is_blank;
  logic       is_digit;

  logic       res_have;
  out_word_t  res;

  logic [VLEN_W-1:0]     vlen_inc;
  logic                  vlen_full;
  attr_mode_t            eff_mode;
  logic [MUL_W-1:0]      cnt_ext, cnt_mul;
  logic [COUNT_BITS-1:0] diff;
  logic [MORE_EXT-1:0]   diff_ext;

  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.byte_in;
  assign last     = in_data.last_byte;
  assign is_blank = (b == CH_SP) || (b == CH_TAB);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // Value byte bookkeeping shared by every value path
  assign vlen_inc  = vlen_r + VLEN_W'(1);
  assign vlen_full = (vlen_inc >= VLEN_W'(VALUE_LIMIT));

  // A closing quote not followed by another one falls back to plain text
  assign eff_mode = (mode_r == AM_QPEND && b != CH_QUOTE) ? AM_PLAIN : mode_r;

  // Count accumulate: value * 10 + digit
  assign cnt_ext = MUL_W'(cnt_r);
  assign cnt_mul = (cnt_ext << 3) + (cnt_ext << 1) + MUL_W'(b - CH_ZERO);

  // Next state and result word for the presented byte
  always_comb begin
    line_nxt  = line_r;
    mode_nxt  = mode_r;
    vlen_nxt  = vlen_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    recv_nxt  = recv_r;
    res_have  = 1'b0;
    res       = '0;
    res.field_id = FID_STATUS;

    if (line_r < LINE_ATTR) begin
      // Header lines: pass bytes, end on newline
      res_have     = 1'b1;
      res.field_id = line_r;
      if (b == CH_NL) begin
        res.field_end = 1'b1;
        line_nxt      = line_r + 3'd1;
      end else begin
        res.byte_out   = b;
        res.byte_valid = 1'b1;
      end
    end else if (line_r == LINE_ATTR) begin
      if (b == CH_NL) begin
        // Close whatever is open and leave the attribute line
        res_have      = 1'b1;
        res.field_end = 1'b1;
        if (mode_r == AM_PLAIN || mode_r == AM_QUOTED || mode_r == AM_QPEND) begin
          res.field_id = FID_VALUE;
        end else begin
          res.field_id     = FID_NAME;
          res.name_dropped = (mode_r == AM_NAME);
        end
        mode_nxt = AM_STOP;
        line_nxt = LINE_COUNT;
      end else begin
        unique case (eff_mode)
          AM_SKIP, AM_NAME: begin
            if (eff_mode == AM_SKIP && is_blank) begin
              mode_nxt = AM_SKIP;
            end else if (eff_mode == AM_SKIP && b == CH_NUL) begin
              mode_nxt = AM_STOP;
            end else if (b == CH_EQ) begin
              res_have      = 1'b1;
              res.field_id  = FID_NAME;
              res.field_end = 1'b1;
              mode_nxt      = AM_PLAIN;
              vlen_nxt      = '0;
            end else if (is_blank || b == CH_NUL) begin
              res_have         = 1'b1;
              res.field_id     = FID_NAME;
              res.field_end    = 1'b1;
              res.name_dropped = 1'b1;
              mode_nxt         = AM_STOP;
            end else begin
              res_have       = 1'b1;
              res.field_id   = FID_NAME;
              res.byte_out   = b;
              res.byte_valid = 1'b1;
              mode_nxt       = AM_NAME;
            end
          end
          AM_PLAIN: begin
            if (is_blank || b == CH_NUL) begin
              res_have      = 1'b1;
              res.field_id  = FID_VALUE;
              res.field_end = 1'b1;
              mode_nxt      = is_blank ? AM_SKIP : AM_STOP;
            end else if (b == CH_QUOTE) begin
              mode_nxt = AM_QUOTED;
            end else begin
              res_have       = 1'b1;
              res.field_id   = FID_VALUE;
              res.byte_out   = b;
              res.byte_valid = 1'b1;
              res.field_end  = vlen_full;
              vlen_nxt       = vlen_inc;
              mode_nxt       = vlen_full ? AM_SKIP : AM_PLAIN;
            end
          end
          AM_QUOTED: begin
            if (b == CH_QUOTE) begin
              mode_nxt = AM_QPEND;
            end else if (b == CH_NUL) begin
              res_have      = 1'b1;
              res.field_id  = FID_VALUE;
              res.field_end = 1'b1;
              mode_nxt      = AM_STOP;
            end else begin
              res_have       = 1'b1;
              res.field_id   = FID_VALUE;
              res.byte_out   = b;
              res.byte_valid = 1'b1;
              res.field_end  = vlen_full;
              vlen_nxt       = vlen_inc;
              mode_nxt       = vlen_full ? AM_SKIP : AM_QUOTED;
            end
          end
          AM_QPEND: begin
            // Doubled quote: emit one quote and stay quoted unless the value limit is hit
            res_have       = 1'b1;
            res.field_id   = FID_VALUE;
            res.byte_out   = b;
            res.byte_valid = 1'b1;
            res.field_end  = vlen_full;
            vlen_nxt       = vlen_inc;
            mode_nxt       = vlen_full ? AM_SKIP : AM_QUOTED;
          end
          AM_STOP: begin
            mode_nxt = AM_STOP;
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
    end else if (line_r == LINE_COUNT) begin
      // Count line: whitespace, sign, digits, then ignore the rest
      if (b == CH_NL) begin
        line_nxt = LINE_DATA;
      end else if (phase_r == CNT_LEAD && (is_blank || b == CH_VT ||
                   b == CH_FF || b == CH_CR)) begin
        phase_nxt = CNT_LEAD;
      end else if (phase_r == CNT_LEAD && (b == CH_PLUS || b == CH_MINUS)) begin
        neg_nxt   = (b == CH_MINUS);
        phase_nxt = CNT_SIGN;
      end else if (phase_r == CNT_DONE) begin
        phase_nxt = CNT_DONE;
      end else if (!is_digit) begin
        phase_nxt = CNT_DONE;
      end else begin
        phase_nxt = CNT_DIGIT;
        if (|cnt_mul[MUL_W-1:COUNT_BITS]) begin
          cnt_nxt = COUNT_MAX;
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_mul[COUNT_BITS-1:0];
        end
      end
    end else begin
      // Data bytes
      res_have       = 1'b1;
      res.field_id   = FID_DATA;
      res.byte_out   = b;
      res.byte_valid = 1'b1;
      if (recv_r != COUNT_MAX) begin
        recv_nxt = recv_r + COUNT_BITS'(1);
      end
    end

    // End of buffer: judge the message
    diff     = cnt_nxt - recv_nxt;
    diff_ext = MORE_EXT'(diff);
    if (last) begin
      res_have = 1'b1;
      if (line_nxt < LINE_DATA) begin
        res.msg_bad = 1'b1;
      end else if (neg_nxt && cnt_nxt != '0) begin
        res.msg_bad = 1'b1;
      end else if (ovf_nxt || cnt_nxt != recv_nxt) begin
        res.msg_bad = 1'b1;
        if (cnt_nxt > recv_nxt) begin
          res.more_needed = (diff_ext > MORE_SAT) ? MORE_SAT[MORE_W-1:0]
                                                  : diff_ext[MORE_W-1:0];
        end
      end else begin
        res.msg_done = 1'b1;
      end
    end
  end

  // Parser state: advance on accept, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      line_r  <= '0;
      mode_r  <= AM_SKIP;
      vlen_r  <= '0;
      phase_r <= CNT_LEAD;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      recv_r  <= '0;
    end else if (accept) begin
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      vlen_r  <= vlen_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      recv_r  <= recv_nxt;
    end
  end

  // Output entry valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept && res_have) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output entry payloads: hold while stalled
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept && res_have) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  // Skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with output register empty");

  // A status word never claims both outcomes
  a_outcome_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.msg_done && out_data_r.msg_bad))
    else $error("message reported both done and bad");

  // Missing bytes are only reported on a bad message
  a_more_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.more_needed != '0) |-> out_data_r.msg_bad)
    else $error("missing byte count without bad status");

  // Last byte restarts the parser at the source line
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (line_r == '0 && recv_r == '0))
    else $error("parser not restarted after last byte");

  // Line position never passes the data section
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= LINE_DATA)
    else $error("line position out of range");

endmodule

`default_nettype wire
